>>> rtl/mlfq_task_scheduler_top_defines.svh
// Assertion macros for the task scheduler.
`ifndef MLFQ_TASK_SCHEDULER_TOP_DEFINES_SVH
`define MLFQ_TASK_SCHEDULER_TOP_DEFINES_SVH
`ifndef SYNTH
`define MLFQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MLFQ_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MLFQ_ASSERT(lbl, clk, rstn, prop, msg)
`define MLFQ_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants of the task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package mlfq_pkg;
  localparam int unsigned Slots    = 64;
  localparam int unsigned TopLevel = 3;
  localparam int unsigned Levels   = TopLevel + 1;
  localparam int unsigned SlotW    = $clog2(Slots);
  localparam int unsigned LinkW    = SlotW + 1;
  localparam int unsigned LvlW     = $clog2(Levels);
  localparam int unsigned CntW     = $clog2(Slots + 1);
  localparam logic [LinkW-1:0] Nil = LinkW'(Slots);

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0, OP_DISPATCH = 3'd1, OP_YIELD = 3'd2, OP_SLEEP = 3'd3,
    OP_WAKEUP = 3'd4, OP_SETPRI = 3'd5, OP_TICK = 3'd6, OP_EXIT = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_FREE = 2'd0, ST_READY = 2'd1, ST_RUN = 2'd2, ST_SLEEP = 2'd3
  } slot_st_e;

  localparam logic [1:0] StsOk = 2'd0, StsEmpty = 2'd1, StsBad = 2'd2, StsFull = 2'd3;
  localparam logic [0:0] CfgBudget = 1'd0, CfgPeriod = 1'd1;

  // One slot entry as kept in memory.
  typedef struct packed {
    slot_st_e          st;
    logic [30:0]       pid;
    logic [2:0]        lvl;
    logic signed [17:0] budget;
    logic [31:0]       chan;
    logic [LinkW-1:0]  link;
  } slot_t;

  // Memory request from the sequencer.
  typedef struct packed {
    logic             rd;
    logic [SlotW-1:0] raddr;
    logic             we;
    logic [SlotW-1:0] waddr;
    slot_t            wdata;
  } mem_req_t;
endpackage
`default_nettype wire

>>> rtl/mlfq_slot_mem.sv
// ----------------------------------------------------------------------------
// mlfq_slot_mem
// Slot table: one write and one registered read port. Valid bits keep
// never-written entries reading as the reset entry (free, chained downward).
// ----------------------------------------------------------------------------
`default_nettype none
module mlfq_slot_mem (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mlfq_pkg::mem_req_t req_i,
  output mlfq_pkg::slot_t        rdata_o
);
  mlfq_pkg::slot_t mem [mlfq_pkg::Slots];
  logic [mlfq_pkg::Slots-1:0] vld_q;
  mlfq_pkg::slot_t raw_q;
  logic rvld_q;
  logic [mlfq_pkg::SlotW-1:0] raddr_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem[req_i.waddr] <= req_i.wdata;
    if (req_i.rd) raw_q <= mem[req_i.raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rvld_q  <= 1'b0;
      raddr_q <= '0;
    end else begin
      if (req_i.we) vld_q[req_i.waddr] <= 1'b1;
      if (req_i.rd) begin
        rvld_q  <= vld_q[req_i.raddr];
        raddr_q <= req_i.raddr;
      end
    end
  end

  always_comb begin
    if (rvld_q) begin
      rdata_o = raw_q;
    end else begin
      rdata_o = '0;
      rdata_o.st = mlfq_pkg::ST_FREE;
      rdata_o.link = (raddr_q == '0) ? mlfq_pkg::Nil
                                     : mlfq_pkg::LinkW'(raddr_q) - 1'b1;
    end
  end
endmodule
`default_nettype wire

>>> rtl/mlfq_seq.sv
// ----------------------------------------------------------------------------
// mlfq_seq
// Operation sequencer: walks slot lists with read-modify-write on the table.
// Reads are issued in one state and their data used in a later one, so no access overlaps a write.
// ----------------------------------------------------------------------------
`default_nettype none
module mlfq_seq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [2:0]         opcode_i,
  input  wire logic [30:0]        task_id_i,
  input  wire logic [15:0]        ticks_used_i,
  input  wire logic [31:0]        channel_i,
  input  wire logic [7:0]         new_level_i,
  input  wire logic [15:0]        budget_ticks_i,
  input  wire logic [15:0]        promote_period_i,
  input  wire mlfq_pkg::slot_t    rdata_i,
  output mlfq_pkg::mem_req_t      req_o,
  output logic                    busy_o,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic [30:0]             result_id_o,
  output logic [2:0]              result_level_o,
  output logic [6:0]              woken_count_o
);
  localparam int unsigned SW = mlfq_pkg::SlotW;
  localparam int unsigned LW = mlfq_pkg::LinkW;
  localparam int unsigned VW = mlfq_pkg::LvlW;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001, S_RD     = 16'h0002, S_CHK    = 16'h0004,
    S_APP_RD = 16'h0008, S_APP_WR = 16'h0010, S_DONE   = 16'h0020,
    S_SRCH   = 16'h0040, S_SCAN   = 16'h0080, S_WK_RD  = 16'h0100,
    S_WK_CHK = 16'h0200, S_UNL    = 16'h0400, S_UNL_CK = 16'h0800,
    S_PR_RD  = 16'h1000, S_PR_CHK = 16'h2000, S_RUNS   = 16'h4000,
    S_RUNC   = 16'h8000
  } state_e;

  // Phases for reuse of shared states.
  typedef enum logic [2:0] {
    P_MAIN = 3'd0, P_SETQ = 3'd1, P_SETS = 3'd2, P_PROMQ = 3'd3, P_PROMA = 3'd4
  } phase_e;

  state_e state_q, state_d;
  phase_e ph_q, ph_d;
  mlfq_pkg::op_e op_q, op_d;
  logic [30:0] pid_q, pid_d;
  logic [15:0] used_q, used_d;
  logic [31:0] chan_q, chan_d;
  logic [7:0]  nl_q, nl_d;
  logic [LW-1:0] rh_q [mlfq_pkg::Levels], rh_d [mlfq_pkg::Levels];
  logic [LW-1:0] rt_q [mlfq_pkg::Levels], rt_d [mlfq_pkg::Levels];
  logic [LW-1:0] sh_q, sh_d, fh_q, fh_d;
  logic [30:0] nid_q, nid_d;
  logic [15:0] tc_q, tc_d;
  logic [SW-1:0] cur_q, cur_d;     // slot under work
  logic [LW-1:0] prev_q, prev_d;   // predecessor in walk
  logic [LW-1:0] walk_q, walk_d;   // next slot to visit
  logic [VW-1:0] lvl_q, lvl_d;     // queue being searched
  logic [VW-1:0] alvl_q, alvl_d;   // queue to append to
  mlfq_pkg::slot_t ent_q, ent_d;   // entry to append
  logic [1:0] sts_q, sts_d;
  logic [30:0] rid_q, rid_d;
  logic [2:0] rlv_q, rlv_d;
  logic [6:0] wk_q, wk_d;
  logic [SW:0] cnt_q, cnt_d;       // run-slot scan counter

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= P_MAIN;
      for (int i = 0; i < mlfq_pkg::Levels; i++) begin
        rh_q[i] <= mlfq_pkg::Nil;
        rt_q[i] <= mlfq_pkg::Nil;
      end
      sh_q  <= mlfq_pkg::Nil;
      fh_q  <= LW'(mlfq_pkg::Slots - 1);
      nid_q <= 31'd1;
      tc_q  <= '0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      rh_q    <= rh_d;
      rt_q    <= rt_d;
      sh_q    <= sh_d;
      fh_q    <= fh_d;
      nid_q   <= nid_d;
      tc_q    <= tc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; pid_q <= pid_d; used_q <= used_d; chan_q <= chan_d; nl_q <= nl_d;
    cur_q <= cur_d; prev_q <= prev_d; walk_q <= walk_d; lvl_q <= lvl_d;
    alvl_q <= alvl_d; ent_q <= ent_d; sts_q <= sts_d; rid_q <= rid_d;
    rlv_q <= rlv_d; wk_q <= wk_d; cnt_q <= cnt_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign status_o       = sts_q;
  assign result_id_o    = rid_q;
  assign result_level_o = rlv_q;
  assign woken_count_o  = wk_q;

  logic signed [17:0] nb;

  always_comb begin
    state_d = state_q; ph_d = ph_q; op_d = op_q; pid_d = pid_q; used_d = used_q;
    chan_d = chan_q; nl_d = nl_q; rh_d = rh_q; rt_d = rt_q; sh_d = sh_q; fh_d = fh_q;
    nid_d = nid_q; tc_d = tc_q; cur_d = cur_q; prev_d = prev_q; walk_d = walk_q;
    lvl_d = lvl_q; alvl_d = alvl_q; ent_d = ent_q; sts_d = sts_q; rid_d = rid_q;
    rlv_d = rlv_q; wk_d = wk_q; cnt_d = cnt_q;
    req_o = '0;
    done_o = 1'b0;
    nb = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d = mlfq_pkg::op_e'(opcode_i); pid_d = task_id_i; used_d = ticks_used_i;
          chan_d = channel_i; nl_d = new_level_i;
          sts_d = mlfq_pkg::StsOk; rid_d = '0; rlv_d = '0; wk_d = '0;
          ph_d = P_MAIN;
          case (mlfq_pkg::op_e'(opcode_i))
            mlfq_pkg::OP_CREATE: begin
              if (fh_q == mlfq_pkg::Nil) begin
                sts_d = mlfq_pkg::StsFull; state_d = S_DONE;
              end else begin
                cur_d = fh_q[SW-1:0];
                req_o.rd = 1'b1; req_o.raddr = fh_q[SW-1:0];
                state_d = S_RD;
              end
            end
            mlfq_pkg::OP_DISPATCH: begin
              sts_d = mlfq_pkg::StsEmpty;
              state_d = S_DONE;
              for (int l = mlfq_pkg::Levels - 1; l >= 0; l--) begin
                if (rh_q[l] != mlfq_pkg::Nil) begin
                  cur_d = rh_q[l][SW-1:0]; lvl_d = VW'(l);
                  state_d = S_RD;
                end
              end
              if (state_d == S_RD) begin
                req_o.rd = 1'b1; req_o.raddr = cur_d;
              end
            end
            mlfq_pkg::OP_WAKEUP: begin
              prev_d = mlfq_pkg::Nil; walk_d = sh_q; state_d = S_WK_RD;
            end
            mlfq_pkg::OP_SETPRI: begin
              if (new_level_i > 8'(mlfq_pkg::TopLevel)) begin
                sts_d = mlfq_pkg::StsBad; state_d = S_DONE;
              end else begin
                ph_d = P_SETQ; lvl_d = '0; walk_d = rh_q[0]; state_d = S_SRCH;
              end
            end
            mlfq_pkg::OP_TICK: begin
              tc_d = tc_q + 16'd1;
              if (tc_d >= promote_period_i) begin
                tc_d = '0;
                ph_d = P_PROMQ; lvl_d = VW'(1); state_d = S_PR_RD;
              end else begin
                state_d = S_DONE;
              end
            end
            default: begin  // yield, sleep, exit: find running pid
              cnt_d = '0; state_d = S_RUNS;
            end
          endcase
        end
      end

      // Generic scan over all slots for a running pid (or promotion sweep).
      S_RUNS: begin
        if (cnt_q == (SW+1)'(mlfq_pkg::Slots)) begin
          if (ph_q == P_PROMA) state_d = S_DONE;
          else begin sts_d = mlfq_pkg::StsBad; state_d = S_DONE; end
        end else begin
          req_o.rd = 1'b1; req_o.raddr = cnt_q[SW-1:0];
          cur_d = cnt_q[SW-1:0];
          state_d = S_RUNC;
        end
      end
      S_RUNC: begin
        cnt_d = cnt_q + 1'b1;
        state_d = S_RUNS;
        if (ph_q == P_PROMA) begin
          if ((rdata_i.st == mlfq_pkg::ST_SLEEP || rdata_i.st == mlfq_pkg::ST_RUN)
              && rdata_i.lvl != '0) begin
            req_o.we = 1'b1; req_o.waddr = cur_q; req_o.wdata = rdata_i;
            req_o.wdata.lvl = rdata_i.lvl - 3'd1;
          end
        end else if (rdata_i.st == mlfq_pkg::ST_RUN && rdata_i.pid == pid_q) begin
          ent_d = rdata_i;
          state_d = S_CHK;
        end
      end

      S_RD: state_d = S_CHK;

      // Apply the operation to the entry just read.
      S_CHK: begin
        state_d = S_DONE;
        case (op_q)
          mlfq_pkg::OP_CREATE: begin
            fh_d = rdata_i.link;
            ent_d = '0;
            ent_d.pid = nid_q; ent_d.budget = 18'(budget_ticks_i);
            rid_d = nid_q;
            nid_d = nid_q + 31'd1;
            alvl_d = '0;
            state_d = S_APP_RD;
          end
          mlfq_pkg::OP_DISPATCH: begin
            rh_d[lvl_q] = rdata_i.link;
            if (rt_q[lvl_q] == LW'(cur_q)) rt_d[lvl_q] = mlfq_pkg::Nil;
            req_o.we = 1'b1; req_o.waddr = cur_q; req_o.wdata = rdata_i;
            req_o.wdata.st = mlfq_pkg::ST_RUN; req_o.wdata.link = mlfq_pkg::Nil;
            rid_d = rdata_i.pid; rlv_d = rdata_i.lvl;
            sts_d = mlfq_pkg::StsOk;
          end
          mlfq_pkg::OP_YIELD: begin
            nb = ent_q.budget - 18'(used_q);
            ent_d = ent_q;
            if (nb <= 0) begin
              if (ent_q.lvl < 3'(mlfq_pkg::TopLevel)) ent_d.lvl = ent_q.lvl + 3'd1;
              ent_d.budget = 18'(budget_ticks_i);
            end else begin
              ent_d.budget = nb;
            end
            alvl_d = ent_d.lvl[VW-1:0];
            state_d = S_APP_RD;
          end
          mlfq_pkg::OP_SLEEP: begin
            req_o.we = 1'b1; req_o.waddr = cur_q; req_o.wdata = ent_q;
            req_o.wdata.chan = chan_q; req_o.wdata.st = mlfq_pkg::ST_SLEEP;
            req_o.wdata.link = sh_q;
            sh_d = LW'(cur_q);
          end
          default: begin  // exit
            req_o.we = 1'b1; req_o.waddr = cur_q; req_o.wdata = '0;
            req_o.wdata.st = mlfq_pkg::ST_FREE; req_o.wdata.link = fh_q;
            fh_d = LW'(cur_q);
          end
        endcase
      end

      // Append ent_q (slot cur_q) to queue alvl_q: link the old tail first.
      S_APP_RD: begin
        if (rh_q[alvl_q] == mlfq_pkg::Nil || rt_q[alvl_q] == mlfq_pkg::Nil) begin
          if (rh_q[alvl_q] == mlfq_pkg::Nil) rh_d[alvl_q] = LW'(cur_q);
          state_d = S_APP_WR;
        end else begin
          req_o.rd = 1'b1; req_o.raddr = rt_q[alvl_q][SW-1:0];
          state_d = S_UNL;
          ph_d = ph_q;
        end
      end
      S_UNL: begin
        // rdata holds old tail entry; relink it to cur
        req_o.we = 1'b1; req_o.waddr = rt_q[alvl_q][SW-1:0]; req_o.wdata = rdata_i;
        req_o.wdata.link = LW'(cur_q);
        state_d = S_APP_WR;
      end
      S_APP_WR: begin
        req_o.we = 1'b1; req_o.waddr = cur_q; req_o.wdata = ent_q;
        req_o.wdata.st = mlfq_pkg::ST_READY; req_o.wdata.link = mlfq_pkg::Nil;
        rt_d[alvl_q] = LW'(cur_q);
        case (ph_q)
          P_PROMQ: state_d = S_PR_RD;
          P_MAIN: state_d = (op_q == mlfq_pkg::OP_WAKEUP) ? S_WK_RD : S_DONE;
          default: state_d = S_DONE;
        endcase
      end

      // Wakeup walk over the sleep list.
      S_WK_RD: begin
        if (walk_q == mlfq_pkg::Nil) state_d = S_DONE;
        else begin
          req_o.rd = 1'b1; req_o.raddr = walk_q[SW-1:0];
          cur_d = walk_q[SW-1:0];
          state_d = S_WK_CHK;
        end
      end
      S_WK_CHK: begin
        walk_d = rdata_i.link;
        if (rdata_i.chan == chan_q) begin
          if (prev_q == mlfq_pkg::Nil) begin
            sh_d = rdata_i.link;
            ent_d = rdata_i; alvl_d = rdata_i.lvl[VW-1:0];
            wk_d = wk_q + 7'd1;
            state_d = S_APP_RD;
          end else begin
            // fix predecessor link, then append
            ent_d = rdata_i; alvl_d = rdata_i.lvl[VW-1:0];
            wk_d = wk_q + 7'd1;
            req_o.rd = 1'b1; req_o.raddr = prev_q[SW-1:0];
            state_d = S_UNL_CK;
          end
        end else begin
          prev_d = LW'(cur_q);
          state_d = S_WK_RD;
        end
      end
      S_UNL_CK: begin
        req_o.we = 1'b1; req_o.waddr = prev_q[SW-1:0]; req_o.wdata = rdata_i;
        req_o.wdata.link = walk_q;
        state_d = S_APP_RD;
      end

      // set_priority search: ready queues, then sleep list, then running.
      S_SRCH: begin
        if (walk_q == mlfq_pkg::Nil) begin
          if (ph_q == P_SETQ && lvl_q != VW'(mlfq_pkg::TopLevel)) begin
            lvl_d = lvl_q + 1'b1; walk_d = rh_q[lvl_d];
          end else if (ph_q == P_SETQ) begin
            ph_d = P_SETS; walk_d = sh_q;
          end else begin
            ph_d = P_MAIN; op_d = mlfq_pkg::OP_SETPRI; cnt_d = '0; state_d = S_SCAN;
          end
          prev_d = mlfq_pkg::Nil;
        end else begin
          req_o.rd = 1'b1; req_o.raddr = walk_q[SW-1:0];
          cur_d = walk_q[SW-1:0];
          state_d = S_SCAN;
          if (ph_q == P_SETQ && walk_q == rh_q[lvl_q]) prev_d = mlfq_pkg::Nil;
        end
      end
      S_SCAN: begin
        if (ph_q == P_MAIN) begin
          // running-slot search reusing the generic scan, with setpri on hit
          if (cnt_q == (SW+1)'(mlfq_pkg::Slots)) begin
            sts_d = mlfq_pkg::StsBad; state_d = S_DONE;
          end else begin
            req_o.rd = 1'b1; req_o.raddr = cnt_q[SW-1:0];
            cur_d = cnt_q[SW-1:0];
            ph_d = P_PROMA;  // marks "running scan of set_priority"
            state_d = S_PR_CHK;
          end
        end else if (rdata_i.pid == pid_q) begin
          if (ph_q == P_SETS) begin
            req_o.we = 1'b1; req_o.waddr = cur_q; req_o.wdata = rdata_i;
            req_o.wdata.lvl = nl_q[2:0];
            state_d = S_DONE;
          end else if (rdata_i.lvl == nl_q[2:0]) begin
            state_d = S_DONE;
          end else begin
            // unlink from queue lvl_q
            ent_d = rdata_i; ent_d.lvl = nl_q[2:0];
            ent_d.budget = 18'(budget_ticks_i);
            alvl_d = nl_q[VW-1:0];
            if (prev_q == mlfq_pkg::Nil) begin
              rh_d[lvl_q] = rdata_i.link;
              if (rt_q[lvl_q] == LW'(cur_q)) rt_d[lvl_q] = mlfq_pkg::Nil;
              ph_d = P_MAIN; op_d = mlfq_pkg::OP_CREATE;
              state_d = S_APP_RD;
            end else begin
              walk_d = rdata_i.link;
              if (rt_q[lvl_q] == LW'(cur_q)) rt_d[lvl_q] = prev_q;
              req_o.rd = 1'b1; req_o.raddr = prev_q[SW-1:0];
              ph_d = P_MAIN; op_d = mlfq_pkg::OP_CREATE;
              state_d = S_UNL_CK;
            end
          end
        end else begin
          prev_d = LW'(cur_q);
          walk_d = rdata_i.link;
          state_d = S_SRCH;
        end
      end

      // Promotion: drain queue lvl_q into lvl_q-1; also set_priority run scan.
      S_PR_RD: begin
        if (ph_q == P_PROMQ) begin
          if (rh_q[lvl_q] == mlfq_pkg::Nil) begin
            rt_d[lvl_q] = mlfq_pkg::Nil;
            if (lvl_q == VW'(mlfq_pkg::TopLevel)) begin
              ph_d = P_PROMA; cnt_d = '0; state_d = S_RUNS;
            end else begin
              lvl_d = lvl_q + 1'b1;
            end
          end else begin
            req_o.rd = 1'b1; req_o.raddr = rh_q[lvl_q][SW-1:0];
            cur_d = rh_q[lvl_q][SW-1:0];
            state_d = S_PR_CHK;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_PR_CHK: begin
        if (ph_q == P_PROMQ) begin
          rh_d[lvl_q] = rdata_i.link;
          ent_d = rdata_i; ent_d.lvl = 3'(lvl_q - 1'b1);
          alvl_d = lvl_q - 1'b1;
          state_d = S_APP_RD;
        end else begin
          ph_d = P_MAIN;
          cnt_d = cnt_q + 1'b1;
          state_d = S_SCAN;
          if (rdata_i.st == mlfq_pkg::ST_RUN && rdata_i.pid == pid_q) begin
            req_o.we = 1'b1; req_o.waddr = cur_q; req_o.wdata = rdata_i;
            req_o.wdata.lvl = nl_q[2:0];
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        done_o = 1'b1;
        ph_d = P_MAIN;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/mlfq_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// mlfq_task_scheduler_top
// Multilevel feedback queue task scheduler over a linked slot table.
// ----------------------------------------------------------------------------
// One command at a time: start is taken while busy is low, and exactly one
// result appears later for one cycle on done_o, which the receiver cannot
// stall. Every slot read is followed by a state that uses the data. Yield,
// sleep and exit scan the slots from 0 upward for the running pid. Wakeup
// passes over the sleepers on other channels and moves each matching one;
// set_priority walks the ready queues and sleep list, then scans for the
// running slot; a promoting tick moves every ready task from queue l to
// queue l-1 and sweeps all 64 slots. The slot table is read one entry at
// a time.
`default_nettype none
`include "mlfq_task_scheduler_top_defines.svh"
module mlfq_task_scheduler_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [30:0] task_id_i,
  input  wire logic [15:0] ticks_used_i,
  input  wire logic [31:0] channel_i,
  input  wire logic [7:0]  new_level_i,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [30:0]      result_id_o,
  output logic [2:0]       result_level_o,
  output logic [6:0]       woken_count_o
);
  logic [15:0] budget_q, period_q;
  mlfq_pkg::mem_req_t req;
  mlfq_pkg::slot_t rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= 16'd100;
      period_q <= 16'd1000;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == mlfq_pkg::CfgBudget) budget_q <= cfg_data_i;
      else period_q <= cfg_data_i;
    end
  end

  mlfq_slot_mem u_mem (.clk_i, .rst_ni, .req_i(req), .rdata_o(rdata));

  mlfq_seq u_seq (
    .clk_i, .rst_ni, .start_i(start), .opcode_i, .task_id_i, .ticks_used_i,
    .channel_i, .new_level_i, .budget_ticks_i(budget_q),
    .promote_period_i(period_q), .rdata_i(rdata), .req_o(req), .busy_o(busy),
    .done_o, .status_o, .result_id_o, .result_level_o, .woken_count_o
  );

  `MLFQ_ASSERT(a_done_busy, clk_i, rst_ni, done_o |-> busy, "result without command")
  `MLFQ_ASSERT(a_start_busy, clk_i, rst_ni, (start && !busy) |=> busy, "command dropped")
  `MLFQ_ASSERT(a_done_once, clk_i, rst_ni, done_o |=> !done_o, "result repeated")
  `MLFQ_ASSERT(a_rw_excl, clk_i, rst_ni, !(req.we && req.rd && req.waddr == req.raddr), "read and write collide")
endmodule
`default_nettype wire
